// ===== sv/pdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the postfix digit calculator: character
// codes, status codes, datapath widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ITER_W = 5;

  // last step of the bit-serial multiply and divide loops
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'd45;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'd42;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'd47;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'd61;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_RD_A   = 11'b000_0000_0100,
    S_RD_B   = 11'b000_0000_1000,
    S_EXEC   = 11'b000_0001_0000,
    S_MUL    = 11'b000_0010_0000,
    S_DIV    = 11'b000_0100_0000,
    S_DFIX   = 11'b000_1000_0000,
    S_WB     = 11'b001_0000_0000,
    S_RD_EQ  = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_e;

endpackage

// ===== sv/postfix_digit_calculator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_digit_calculator_core
// Evaluates a postfix expression one character per transfer on a value stack
// held in a single-port-write memory, with one shared 33-bit adder/subtractor
// doing add, subtract, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
// One input character is taken per transfer; the block drops in_ready_o while
// it works on it. A digit (or any non-operator byte) is pushed as its code
// minus 48. '*' and '/' each walk 32 steps through the shared adder, one
// product or quotient bit a step, and that loop sets the worst-case rate.
// '=', like every error, hands one result (value, status) to a single output
// register; the block goes back to accepting characters while that result
// waits to be taken, and only stalls when a second result finds the register
// still full. After every result, error or not, the stack is emptied. Stack
// memory contents are not cleared at reset; only entries below the stack
// count are ever used.
// ----------------------------------------------------------------------------
module postfix_digit_calculator_core
  import pdc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CHAR_W-1:0]        char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [STAT_W-1:0]        status_o
);

  // count needs to hold STACK_DEPTH itself, the address only its entries
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // control state
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [CHAR_W-1:0] char_q, char_d;
  logic [DATA_W-1:0] a_q, a_d;       // top operand, later divisor magnitude
  logic [DATA_W-1:0] b_q, b_d;       // second operand, shifted multiplicand
  logic [DATA_W-1:0] acc_q, acc_d;   // result, product or remainder
  logic [DATA_W-1:0] quo_q, quo_d;   // multiplier or dividend/quotient
  logic              neg_q, neg_d;
  status_e           stat_q, stat_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  // stack memory
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // shared adder/subtractor, bit 32 is the borrow on subtract
  logic [DATA_W-1:0] alu_x, alu_y;
  logic              alu_sub;
  logic [DATA_W:0]   alu_sum;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              slot_free;
  logic              in_xfer;
  logic [DATA_W-1:0] rem_sh;

  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_m2    = cnt_q - CW'(2);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign rem_sh     = {acc_q[DATA_W-2:0], quo_q[DATA_W-1]};

  assign alu_sum = {1'b0, alu_x} + ({1'b0, alu_y} ^ {(DATA_W+1){alu_sub}})
                 + {{DATA_W{1'b0}}, alu_sub};

  // operand routing into the shared unit
  always_comb begin
    alu_x   = acc_q;
    alu_y   = a_q;
    alu_sub = 1'b0;
    case (state_q)
      S_EXEC: begin
        alu_x   = b_q;
        alu_y   = a_q;
        alu_sub = (char_q == CH_MINUS);
      end
      S_MUL: begin
        alu_x = acc_q;
        alu_y = quo_q[0] ? b_q : '0;
      end
      S_DIV: begin
        alu_x   = rem_sh;
        alu_y   = a_q;
        alu_sub = 1'b1;
      end
      S_DFIX: begin
        alu_x   = '0;
        alu_y   = quo_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_x   = acc_q;
        alu_y   = a_q;
        alu_sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    iter_d       = iter_q;
    out_valid_d  = out_valid_q;
    char_d       = char_q;
    a_d          = a_q;
    b_d          = b_q;
    acc_d        = acc_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    stat_d       = stat_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    rd_addr      = cnt_m1[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[AW-1:0];
    mem_wdata    = {{(DATA_W-CHAR_W){1'b0}}, char_q} - DATA_W'(CH_ZERO);

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          char_d  = char_code_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (char_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
          if (cnt_q < CW'(2)) begin
            acc_d   = '0;
            stat_d  = ST_MALFORMED;
            state_d = S_EMIT;
          end else begin
            rd_addr = cnt_m1[AW-1:0];
            state_d = S_RD_A;
          end
        end else if (char_q == CH_EQUALS) begin
          if (cnt_q != CW'(1)) begin
            acc_d   = '0;
            stat_d  = ST_MALFORMED;
            state_d = S_EMIT;
          end else begin
            rd_addr = '0;
            state_d = S_RD_EQ;
          end
        end else if (cnt_q >= CW'(STACK_DEPTH)) begin
          acc_d   = '0;
          stat_d  = ST_OVERFLOW;
          state_d = S_EMIT;
        end else begin
          // push character code minus 48
          mem_we  = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          state_d = S_IDLE;
        end
      end
      S_RD_A: begin
        a_d     = rd_data_q;
        rd_addr = cnt_m2[AW-1:0];
        state_d = S_RD_B;
      end
      S_RD_B: begin
        b_d     = rd_data_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        case (char_q)
          CH_STAR: begin
            acc_d   = '0;
            quo_d   = a_q;
            iter_d  = '0;
            state_d = S_MUL;
          end
          CH_SLASH: begin
            if (a_q == '0) begin
              acc_d   = '0;
              stat_d  = ST_DIVZERO;
              state_d = S_EMIT;
            end else begin
              // work on magnitudes, fix the sign after the loop
              a_d     = a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
              quo_d   = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;
              neg_d   = a_q[DATA_W-1] ^ b_q[DATA_W-1];
              acc_d   = '0;
              iter_d  = '0;
              state_d = S_DIV;
            end
          end
          default: begin
            acc_d   = alu_sum[DATA_W-1:0];
            state_d = S_WB;
          end
        endcase
      end
      S_MUL: begin
        // shift-add, one multiplier bit a step
        acc_d  = alu_sum[DATA_W-1:0];
        b_d    = {b_q[DATA_W-2:0], 1'b0};
        quo_d  = {1'b0, quo_q[DATA_W-1:1]};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        // restoring step, one quotient bit a step
        if (!alu_sum[DATA_W]) begin
          acc_d = alu_sum[DATA_W-1:0];
        end else begin
          acc_d = rem_sh;
        end
        quo_d  = {quo_q[DATA_W-2:0], ~alu_sum[DATA_W]};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) begin
          state_d = S_DFIX;
        end
      end
      S_DFIX: begin
        acc_d   = neg_q ? alu_sum[DATA_W-1:0] : quo_q;
        state_d = S_WB;
      end
      S_WB: begin
        // result replaces the second operand, one value fewer
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[AW-1:0];
        mem_wdata = acc_q;
        cnt_d     = cnt_m1;
        state_d   = S_IDLE;
      end
      S_RD_EQ: begin
        acc_d   = rd_data_q;
        stat_d  = ST_OK;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = acc_q;
          out_status_d = stat_q;
          cnt_d        = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q       <= char_d;
    a_q          <= a_d;
    b_q          <= b_d;
    acc_q        <= acc_d;
    quo_q        <= quo_d;
    neg_q        <= neg_d;
    stat_q       <= stat_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the sequencer is busy in the cycle after every input transfer
  a_busy_after_xfer : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o
  ) else $error("ready high straight after an input transfer");

  // error results always carry a zero value
  a_err_value_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (value_o == '0)
  ) else $error("error result with nonzero value");

  // the stack never holds more than its depth
  a_cnt_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)
  ) else $error("stack count beyond depth");

  // loading a result empties the stack and fills the output register
  a_emit_clears : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && slot_free) |=> (cnt_q == '0 && out_valid_o)
  ) else $error("result load did not clear the stack");

endmodule

// ===== bench/postfix_digit_calculator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_digit_calculator_core_tb
// Self-checking bench for the postfix calculator. A short table of characters
// covers the edge cases, and random postfix expressions, stack overflows,
// wrapping divides, noise and broken expressions follow. A shadow stack
// predicts every result, and the results are compared in order under random
// stalls on both handshakes.
// ----------------------------------------------------------------------------
module postfix_digit_calculator_core_tb;
  import pdc_pkg::*;

  localparam int unsigned STACK_DEPTH      = 16;
  localparam int unsigned PHASE_ITEMS      = 584;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned DIRECTED_ROWS    = 24;
  localparam int unsigned MAX_REPORTS      = 10;
  // byte 0xb0 pushes 128, the building block for the most negative value
  localparam logic [CHAR_W-1:0] CH_POW7    = 8'hB0;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } result_t;

  // one row of the directed table; typed rows carry their result in full
  typedef struct packed {
    logic [CHAR_W-1:0]        code;
    logic                     typed;
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CHAR_W-1:0]        char_code;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] value;
  logic [STAT_W-1:0]        status;

  // shadow copy of the value stack
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth;

  result_t           answer_q [$];
  logic [CHAR_W-1:0] char_backlog [$];

  int unsigned failures;
  int unsigned items_sent;
  int unsigned phase_items;
  int unsigned results_checked;
  int unsigned status_seen [4];
  int unsigned run_phase;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  logic        long_hold_done;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // straight after reset: nothing on the stack
    '{CH_EQUALS,           1'b1, 32'sd0, ST_MALFORMED},
    '{CH_STAR,             1'b1, 32'sd0, ST_MALFORMED},
    // operator with a single operand
    '{CH_ZERO + 8'd9,      1'b0, 32'sd0, ST_OK},
    '{CH_SLASH,            1'b1, 32'sd0, ST_MALFORMED},
    // divide by zero
    '{CH_ZERO + 8'd5,      1'b0, 32'sd0, ST_OK},
    '{CH_ZERO,             1'b0, 32'sd0, ST_OK},
    '{CH_SLASH,            1'b1, 32'sd0, ST_DIVZERO},
    // byte extremes pushed as 207 and -48, then subtract, multiply and add
    '{8'hFF,               1'b0, 32'sd0, ST_OK},
    '{8'h00,               1'b0, 32'sd0, ST_OK},
    '{CH_MINUS,            1'b0, 32'sd0, ST_OK},
    '{CH_ZERO + 8'd3,      1'b0, 32'sd0, ST_OK},
    '{CH_STAR,             1'b0, 32'sd0, ST_OK},
    '{CH_ZERO + 8'd7,      1'b0, 32'sd0, ST_OK},
    '{CH_PLUS,             1'b0, 32'sd0, ST_OK},
    '{CH_EQUALS,           1'b0, 32'sd0, ST_OK},
    // negative quotient truncates toward zero
    '{CH_ZERO,             1'b0, 32'sd0, ST_OK},
    '{CH_ZERO + 8'd7,      1'b0, 32'sd0, ST_OK},
    '{CH_MINUS,            1'b0, 32'sd0, ST_OK},
    '{CH_ZERO + 8'd2,      1'b0, 32'sd0, ST_OK},
    '{CH_SLASH,            1'b0, 32'sd0, ST_OK},
    '{CH_EQUALS,           1'b0, 32'sd0, ST_OK},
    // equals with two values left
    '{CH_ZERO + 8'd1,      1'b0, 32'sd0, ST_OK},
    '{CH_ZERO + 8'd2,      1'b0, 32'sd0, ST_OK},
    '{CH_EQUALS,           1'b1, 32'sd0, ST_MALFORMED}
  };

  postfix_digit_calculator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .char_code_i(char_code),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .value_o    (value),
    .status_o   (status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // shadow evaluation of one character; emits is set when a result leaves
  task automatic eval_char(input logic [CHAR_W-1:0] code, output logic emits,
                           output result_t res);
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] outcome;
    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W-1:0] quo;
    emits      = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    case (code)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
        if (shadow_depth < 2) begin
          emits      = 1'b1;
          res.status = ST_MALFORMED;
        end else begin
          // a is the top of the stack, b the one below: result is b op a
          opnd_a = shadow_stack[shadow_depth - 1];
          opnd_b = shadow_stack[shadow_depth - 2];
          if (code == CH_SLASH && opnd_a == '0) begin
            emits      = 1'b1;
            res.status = ST_DIVZERO;
          end else begin
            case (code)
              CH_PLUS:  outcome = opnd_b + opnd_a;
              CH_MINUS: outcome = opnd_b - opnd_a;
              CH_STAR:  outcome = opnd_b * opnd_a;
              default: begin
                // divide the magnitudes and put the sign back: truncates toward
                // zero, and the most negative value over minus one wraps
                num_mag = opnd_b[DATA_W-1] ? -opnd_b : opnd_b;
                den_mag = opnd_a[DATA_W-1] ? -opnd_a : opnd_a;
                quo     = num_mag / den_mag;
                outcome = (opnd_b[DATA_W-1] ^ opnd_a[DATA_W-1]) ? -quo : quo;
              end
            endcase
            shadow_depth--;
            shadow_stack[shadow_depth - 1] = outcome;
          end
        end
      end
      CH_EQUALS: begin
        emits = 1'b1;
        if (shadow_depth != 1) begin
          res.status = ST_MALFORMED;
        end else begin
          res.value = shadow_stack[0];
        end
      end
      default: begin
        if (shadow_depth >= STACK_DEPTH) begin
          emits      = 1'b1;
          res.status = ST_OVERFLOW;
        end else begin
          shadow_stack[shadow_depth] = {{(DATA_W-CHAR_W){1'b0}}, code} - DATA_W'(CH_ZERO);
          shadow_depth++;
        end
      end
    endcase
    if (emits) begin
      shadow_depth = 0;
    end
  endtask

  // offer one character, wait for its transfer and predict its outcome
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic typed,
                           input result_t typed_res);
    logic    emits;
    result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    char_code <= code;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    phase_items++;
    eval_char(code, emits, res);
    if (typed) begin
      answer_q.push_back(typed_res);
    end else if (emits) begin
      answer_q.push_back(res);
    end
  endtask

  function automatic logic [CHAR_W-1:0] rand_operand();
    logic [CHAR_W-1:0] pick;
    if ($urandom_range(99) < 85) begin
      return CH_ZERO + CHAR_W'($urandom_range(9));
    end
    // any other byte that is not an operator or equals
    do begin
      pick = CHAR_W'($urandom_range(255));
    end while (pick == CH_PLUS || pick == CH_MINUS || pick == CH_STAR ||
               pick == CH_SLASH || pick == CH_EQUALS);
    return pick;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // queue a postfix expression with the given number of operands; its stack
  // depth never exceeds the operand count
  task automatic build_expression(input int unsigned leaves, input logic closed);
    int unsigned left;
    int unsigned depth;
    left  = leaves;
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(1) == 0)) begin
        char_backlog.push_back(rand_operand());
        left--;
        depth++;
      end else begin
        char_backlog.push_back(rand_operator());
        depth--;
      end
    end
    if (closed) begin
      char_backlog.push_back(CH_EQUALS);
    end
  endtask

  function automatic int unsigned rand_leaves();
    if ($urandom_range(99) < 80) begin
      return $urandom_range(6, 1);
    end
    return $urandom_range(STACK_DEPTH, 7);
  endfunction

  // queue one random sequence: mostly well-formed, the rest edge cases and junk
  task automatic build_sequence();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      build_expression(rand_leaves(), 1'b1);
    end else if (pick < 72) begin
      // fill the stack, then one push too many
      repeat (STACK_DEPTH + 1) char_backlog.push_back(rand_operand());
      if ($urandom_range(1) == 1) begin
        char_backlog.push_back(CH_EQUALS);
      end
    end else if (pick < 77) begin
      // 128^4 * 8 wraps to the most negative value
      char_backlog.push_back(CH_POW7);
      repeat (3) begin
        char_backlog.push_back(CH_POW7);
        char_backlog.push_back(CH_STAR);
      end
      char_backlog.push_back(CH_ZERO + 8'd8);
      char_backlog.push_back(CH_STAR);
      case ($urandom_range(3))
        0: begin
          // over minus one
          char_backlog.push_back(CH_ZERO);
          char_backlog.push_back(CH_ZERO + 8'd1);
          char_backlog.push_back(CH_MINUS);
          char_backlog.push_back(CH_SLASH);
        end
        1: begin
          // times minus one
          char_backlog.push_back(CH_ZERO);
          char_backlog.push_back(CH_ZERO + 8'd1);
          char_backlog.push_back(CH_MINUS);
          char_backlog.push_back(CH_STAR);
        end
        2: begin
          // minus one gives the most positive value
          char_backlog.push_back(CH_ZERO + 8'd1);
          char_backlog.push_back(CH_MINUS);
        end
        default: ;
      endcase
      char_backlog.push_back(CH_EQUALS);
    end else if (pick < 87) begin
      repeat ($urandom_range(8, 1)) char_backlog.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: build_expression(rand_leaves(), 1'b0);
        1: begin
          build_expression(rand_leaves(), 1'b0);
          char_backlog.push_back(rand_operator());
          char_backlog.push_back(CH_EQUALS);
        end
        default: begin
          build_expression(rand_leaves(), 1'b0);
          build_expression(rand_leaves(), 1'b1);
        end
      endcase
    end
  endtask

  // stimulus
  initial begin : char_source
    result_t typed_res;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    char_code      = '0;
    shadow_depth   = 0;
    failures       = 0;
    items_sent     = 0;
    phase_items    = 0;
    run_phase      = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 73;
    long_hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_res.value  = directed_rows[i].value;
      typed_res.status = directed_rows[i].status;
      send_char(directed_rows[i].code, directed_rows[i].typed, typed_res);
    end

    for (int p = 0; p < 3; p++) begin
      run_phase   = p;
      phase_items = 0;
      case (p)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (phase_items < PHASE_ITEMS) begin
        build_sequence();
        while (char_backlog.size() != 0) begin
          send_char(char_backlog.pop_front(), 1'b0, typed_res);
        end
      end
      // let every result come home before the next phase or the end
      in_valid <= 1'b0;
      do @(posedge clk); while (answer_q.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", answer_q.size()));
    end
    $display("run covered %0d characters under three stall patterns, %0d results",
             items_sent, results_checked);
    $display("status mix: ok %0d, malformed %0d, divide by zero %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side stalls, plus one long hold-off that backs the block up
  initial begin : result_sink
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && run_phase == 2 && phase_items >= 100) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      status_seen[status]++;
      if (answer_q.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d status %0d", value, status));
      end else begin
        want = answer_q.pop_front();
        if (value !== want.value || status !== want.status) begin
          note_failure($sformatf("mismatch: expected value %0d status %0d, got value %0d status %0d",
                                 want.value, want.status, value, status));
        end
      end
    end
  end

  // end the run if nothing moves on either side for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", stall_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
